// ===== rtl/core/mipd_pkg.sv =====
// mipd_pkg: shared constants and types for the minimum-image pair distance block
// used by every module under rtl/core; depends on nothing

package mipd_pkg;

   // coordinate format
   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int FRACTION_BITS       = 12;

   // box length after reset, in whole units (1024.0)
   localparam int BOX_RESET_UNITS = 1024;

   // width of the length result field
   localparam int LENGTH_WIDTH = 62;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // register port
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_LSB  = 2;

   // register indexes
   typedef enum logic [1:0] {
      REG_BOX_X = 2'd0,
      REG_BOX_Y = 2'd1,
      REG_BOX_Z = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/core/mipd_csr.sv =====
// mipd_csr: box length registers behind the register port
// depends on mipd_pkg

module mipd_csr #(
   parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mipd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mipd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [mipd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output logic [COORD_WIDTH-1:0]              box_x,
   output logic [COORD_WIDTH-1:0]              box_y,
   output logic [COORD_WIDTH-1:0]              box_z
);

   localparam logic [COORD_WIDTH-1:0] BOX_RESET =
      COORD_WIDTH'(mipd_pkg::BOX_RESET_UNITS << mipd_pkg::FRACTION_BITS);
   localparam int IW = 2;

   logic [COORD_WIDTH-1:0] box_x_ff, box_x_in;
   logic [COORD_WIDTH-1:0] box_y_ff, box_y_in;
   logic [COORD_WIDTH-1:0] box_z_ff, box_z_in;
   logic                   write_en;
   logic [IW-1:0]          index;

   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign index      = csr_paddr[mipd_pkg::CSR_INDEX_LSB +: IW];
   assign csr_pready = 1'b1;

   // register writes, unknown indexes ignored
   always_comb begin
      box_x_in = box_x_ff;
      box_y_in = box_y_ff;
      box_z_in = box_z_ff;
      if (write_en) begin
         case (index)
            mipd_pkg::REG_BOX_X: box_x_in = csr_pwdata[COORD_WIDTH-1:0];
            mipd_pkg::REG_BOX_Y: box_y_in = csr_pwdata[COORD_WIDTH-1:0];
            mipd_pkg::REG_BOX_Z: box_z_in = csr_pwdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BOX_RESET;
         box_y_ff <= BOX_RESET;
         box_z_ff <= BOX_RESET;
      end else begin
         box_x_ff <= box_x_in;
         box_y_ff <= box_y_in;
         box_z_ff <= box_z_in;
      end
   end

   // read back
   always_comb begin
      case (index)
         mipd_pkg::REG_BOX_X: csr_prdata = mipd_pkg::CSR_DATA_WIDTH'(box_x_ff);
         mipd_pkg::REG_BOX_Y: csr_prdata = mipd_pkg::CSR_DATA_WIDTH'(box_y_ff);
         mipd_pkg::REG_BOX_Z: csr_prdata = mipd_pkg::CSR_DATA_WIDTH'(box_z_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign box_x = box_x_ff;
   assign box_y = box_y_ff;
   assign box_z = box_z_ff;

endmodule

// ===== rtl/core/mipd_front.sv =====
// mipd_front: accepts point pairs, forms the deltas and applies the single box wrap
// depends on mipd_pkg; feeds mipd_queue

module mipd_front #(
   parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [COORD_WIDTH-1:0] first_x,
   input  logic [COORD_WIDTH-1:0] first_y,
   input  logic [COORD_WIDTH-1:0] first_z,
   input  logic [COORD_WIDTH-1:0] second_x,
   input  logic [COORD_WIDTH-1:0] second_y,
   input  logic [COORD_WIDTH-1:0] second_z,
   input  logic [COORD_WIDTH-1:0] box_x,
   input  logic [COORD_WIDTH-1:0] box_y,
   input  logic [COORD_WIDTH-1:0] box_z,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic                   push_op,
   output logic [COORD_WIDTH+1:0] push_dx,
   output logic [COORD_WIDTH+1:0] push_dy,
   output logic [COORD_WIDTH+1:0] push_dz
);

   localparam int C  = COORD_WIDTH;
   localparam int DW = COORD_WIDTH + 2;

   logic [C-1:0]  first_v  [3];
   logic [C-1:0]  second_v [3];
   logic [C-1:0]  box_v    [3];

   logic          adv;
   logic          f1_valid_ff, f1_valid_in;
   logic          f2_valid_ff, f2_valid_in;
   logic          f1_op_ff;
   logic          f2_op_ff;
   logic [C:0]    d_ff  [3];
   logic [C:0]    d_in  [3];
   logic [C:0]    nd_ff [3];
   logic [C:0]    nd_in [3];
   logic [DW-1:0] w_ff  [3];
   logic [DW-1:0] w_in  [3];

   assign first_v[0]  = first_x;
   assign first_v[1]  = first_y;
   assign first_v[2]  = first_z;
   assign second_v[0] = second_x;
   assign second_v[1] = second_y;
   assign second_v[2] = second_z;
   assign box_v[0]    = box_x;
   assign box_v[1]    = box_y;
   assign box_v[2]    = box_z;

   // both stages move together unless the last one is stuck on a full queue
   assign adv       = !f2_valid_ff || push_ready;
   assign req_ready = adv;

   assign f1_valid_in = adv ? req_valid   : f1_valid_ff;
   assign f2_valid_in = adv ? f1_valid_ff : f2_valid_ff;

   // stage 1: delta and its negation side by side
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d_in[a]  = {second_v[a][C-1], second_v[a]} - {first_v[a][C-1], first_v[a]};
         nd_in[a] = {first_v[a][C-1], first_v[a]} - {second_v[a][C-1], second_v[a]};
      end
   end

   // stage 2: wrap once toward zero when twice the magnitude exceeds the box
   always_comb begin
      logic          neg;
      logic [C:0]    mag;
      logic          over;
      logic [DW-1:0] d_ext;
      logic [DW-1:0] box_ext;
      for (int a = 0; a < 3; a++) begin
         neg     = d_ff[a][C];
         mag     = neg ? nd_ff[a] : d_ff[a];
         over    = {mag, 1'b0} > {2'b00, box_v[a]};
         d_ext   = {d_ff[a][C], d_ff[a]};
         box_ext = {2'b00, box_v[a]};
         if (!over)
            w_in[a] = d_ext;
         else if (neg)
            w_in[a] = d_ext + box_ext;
         else
            w_in[a] = d_ext - box_ext;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_op_ff <= req_op;
         f2_op_ff <= f1_op_ff;
         for (int a = 0; a < 3; a++) begin
            d_ff[a]  <= d_in[a];
            nd_ff[a] <= nd_in[a];
            w_ff[a]  <= w_in[a];
         end
      end
   end

   assign push_valid = f2_valid_ff;
   assign push_op    = f2_op_ff;
   assign push_dx    = w_ff[0];
   assign push_dy    = w_ff[1];
   assign push_dz    = w_ff[2];

endmodule

// ===== rtl/core/mipd_queue.sv =====
// mipd_queue: short first-in first-out queue of wrapped requests between front and back
// depends on mipd_pkg

module mipd_queue #(
   parameter int DATA_WIDTH = 1 + 3 * (mipd_pkg::COORD_WIDTH_DEFAULT + 2)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int DEPTH = mipd_pkg::QUEUE_DEPTH;
   localparam int PTRW  = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);
   localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(DEPTH);
   localparam logic [PTRW-1:0] LAST_PTR   = PTRW'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTRW-1:0]       head_ff, head_in;
   logic [PTRW-1:0]       tail_ff, tail_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[head_ff];

   // pointer and fill level
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push)
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      if (pop)
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[tail_ff] <= push_data;
   end

   // fill level stays within the queue
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("queue fill level beyond depth");

   // pointers agree with the fill level when empty or full
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> head_ff == tail_ff)
      else $error("queue pointers disagree with fill level");

   // a push into a nonfull queue without pop raises the level by one
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue push lost");

endmodule

// ===== rtl/core/mipd_back.sv =====
// mipd_back: squares, sums and pipelined floor square root of the wrapped deltas
// depends on mipd_pkg; takes requests from mipd_queue

module mipd_back #(
   parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  logic                              pop_op,
   input  logic [COORD_WIDTH+1:0]            pop_dx,
   input  logic [COORD_WIDTH+1:0]            pop_dy,
   input  logic [COORD_WIDTH+1:0]            pop_dz,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [COORD_WIDTH+1:0]            rsp_dx,
   output logic [COORD_WIDTH+1:0]            rsp_dy,
   output logic [COORD_WIDTH+1:0]            rsp_dz,
   output logic [mipd_pkg::LENGTH_WIDTH-1:0] rsp_length
);

   localparam int DW = COORD_WIDTH + 2;
   localparam int PW = 3 * DW + 1;
   localparam int MW = COORD_WIDTH;
   localparam int QW = 2 * COORD_WIDTH;
   localparam int SW = 2 * COORD_WIDTH + 2;
   localparam int RB = COORD_WIDTH + 1;
   localparam int RW = RB + 2;
   localparam int LW = mipd_pkg::LENGTH_WIDTH;

   logic          adv;
   logic [DW-1:0] pop_d  [3];
   logic [DW-1:0] neg_d  [3];
   logic [MW-1:0] mag_in [3];

   logic          b0_valid_ff, b1_valid_ff, b2_valid_ff, b3_valid_ff;
   logic [PW-1:0] b0_pass_ff, b1_pass_ff, b2_pass_ff, b3_pass_ff;
   logic [MW-1:0] b0_mag_ff [3];
   logic [QW-1:0] b1_sq_ff  [3];
   logic [QW:0]   b2_sab_ff;
   logic [QW-1:0] b2_sc_ff;
   logic [SW-1:0] b3_sum_ff;

   logic          rt_valid_ff [RB];
   logic [PW-1:0] rt_pass_ff  [RB];
   logic [SW-1:0] rt_sum_ff   [RB];
   logic [RW-1:0] rt_rem_ff   [RB];
   logic [RW-1:0] rt_rem_in   [RB];
   logic [RB-1:0] rt_root_ff  [RB];
   logic [RB-1:0] rt_root_in  [RB];
   logic          rt_valid_src [RB];
   logic [PW-1:0] rt_pass_src  [RB];
   logic [SW-1:0] rt_sum_src   [RB];
   logic [RW-1:0] rt_rem_src   [RB];
   logic [RB-1:0] rt_root_src  [RB];

   logic          out_valid_ff;
   logic [PW-1:0] out_pass_ff;
   logic [LW-1:0] out_len_ff, out_len_in;
   logic [PW-1:0] last_pass;

   // whole pipeline advances while the output register can move
   assign adv       = !out_valid_ff || rsp_ready;
   assign pop_ready = adv;

   assign pop_d[0] = pop_dx;
   assign pop_d[1] = pop_dy;
   assign pop_d[2] = pop_dz;

   // magnitudes of the wrapped deltas, always below two to the coordinate width
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         neg_d[a]  = -pop_d[a];
         mag_in[a] = pop_d[a][DW-1] ? neg_d[a][MW-1:0] : pop_d[a][MW-1:0];
      end
   end

   // square root stage inputs
   generate
      for (genvar k = 0; k < RB; k++) begin : g_root
         logic [RW+1:0] rem_sh;
         logic [RW+1:0] trial;
         logic [RW+1:0] diff;
         logic          ge;

         if (k == 0) begin : g_first
            assign rt_valid_src[k] = b3_valid_ff;
            assign rt_pass_src[k]  = b3_pass_ff;
            assign rt_sum_src[k]   = b3_sum_ff;
            assign rt_rem_src[k]   = '0;
            assign rt_root_src[k]  = '0;
         end else begin : g_next
            assign rt_valid_src[k] = rt_valid_ff[k-1];
            assign rt_pass_src[k]  = rt_pass_ff[k-1];
            assign rt_sum_src[k]   = rt_sum_ff[k-1];
            assign rt_rem_src[k]   = rt_rem_ff[k-1];
            assign rt_root_src[k]  = rt_root_ff[k-1];
         end

         // one root bit: bring down two radicand bits, try root*4+1
         assign rem_sh = {rt_rem_src[k], rt_sum_src[k][SW-1-2*k -: 2]};
         assign trial  = {2'b00, rt_root_src[k], 2'b01};
         assign diff   = rem_sh - trial;
         assign ge     = rem_sh >= trial;
         assign rt_rem_in[k]  = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
         assign rt_root_in[k] = {rt_root_src[k][RB-2:0], ge};
      end
   endgenerate

   // length selected by op
   assign last_pass  = rt_pass_ff[RB-1];
   assign out_len_in = last_pass[PW-1] ? LW'(rt_root_ff[RB-1]) : LW'(rt_sum_ff[RB-1]);

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < RB; k++)
            rt_valid_ff[k] <= 1'b0;
      end else if (adv) begin
         b0_valid_ff  <= pop_valid;
         b1_valid_ff  <= b0_valid_ff;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         out_valid_ff <= rt_valid_ff[RB-1];
         for (int k = 0; k < RB; k++)
            rt_valid_ff[k] <= rt_valid_src[k];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         b0_pass_ff <= {pop_op, pop_dz, pop_dy, pop_dx};
         for (int a = 0; a < 3; a++) begin
            b0_mag_ff[a] <= mag_in[a];
            b1_sq_ff[a]  <= b0_mag_ff[a] * b0_mag_ff[a];
         end
         b1_pass_ff <= b0_pass_ff;
         b2_pass_ff <= b1_pass_ff;
         b2_sab_ff  <= {1'b0, b1_sq_ff[0]} + {1'b0, b1_sq_ff[1]};
         b2_sc_ff   <= b1_sq_ff[2];
         b3_pass_ff <= b2_pass_ff;
         b3_sum_ff  <= {1'b0, b2_sab_ff} + {2'b00, b2_sc_ff};
         for (int k = 0; k < RB; k++) begin
            rt_pass_ff[k] <= rt_pass_src[k];
            rt_sum_ff[k]  <= rt_sum_src[k];
            rt_rem_ff[k]  <= rt_rem_in[k];
            rt_root_ff[k] <= rt_root_in[k];
         end
         out_pass_ff <= last_pass;
         out_len_ff  <= out_len_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_dx     = out_pass_ff[0 +: DW];
   assign rsp_dy     = out_pass_ff[DW +: DW];
   assign rsp_dz     = out_pass_ff[2*DW +: DW];
   assign rsp_length = out_len_ff;

endmodule

// ===== rtl/core/minimum_image_pair_distance_top.sv =====
// minimum_image_pair_distance_top: minimum-image pair distance.
// A request passes through two front stages, the queue, four square-and-sum stages,
// COORD_WIDTH + 1 root stages (one root bit each) and the output register.
// Throughput is one request per cycle while rsp_tready keeps the output moving.
// Synchronous active-high reset empties the pipeline and queue and sets every box
// length to 1024.0; no memory clearing pass is needed.

module minimum_image_pair_distance_top #(
   parameter int COORD_WIDTH = mipd_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, zero fill
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]  req_tdata,
   // op
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // wrapped_dx, wrapped_dy, wrapped_dz, length_value, zero fill
   output logic [((3*(COORD_WIDTH+2)+mipd_pkg::LENGTH_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mipd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mipd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [mipd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   localparam int C   = COORD_WIDTH;
   localparam int DW  = COORD_WIDTH + 2;
   localparam int QDW = 1 + 3 * DW;
   localparam int ODW = ((3*(COORD_WIDTH+2)+mipd_pkg::LENGTH_WIDTH+7)/8)*8;

   logic [C-1:0]   box_x, box_y, box_z;
   logic           push_valid, push_ready, push_op;
   logic [DW-1:0]  push_dx, push_dy, push_dz;
   logic           pop_valid, pop_ready;
   logic [QDW-1:0] pop_data;
   logic [DW-1:0]  rsp_dx, rsp_dy, rsp_dz;
   logic [mipd_pkg::LENGTH_WIDTH-1:0] rsp_length;

   // box length registers
   mipd_csr #(.COORD_WIDTH(COORD_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .box_x       (box_x),
      .box_y       (box_y),
      .box_z       (box_z)
   );

   // delta and wrap
   mipd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .first_x    (req_tdata[0*C +: C]),
      .first_y    (req_tdata[1*C +: C]),
      .first_z    (req_tdata[2*C +: C]),
      .second_x   (req_tdata[3*C +: C]),
      .second_y   (req_tdata[4*C +: C]),
      .second_z   (req_tdata[5*C +: C]),
      .box_x      (box_x),
      .box_y      (box_y),
      .box_z      (box_z),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .push_dx    (push_dx),
      .push_dy    (push_dy),
      .push_dz    (push_dz)
   );

   // decoupling queue
   mipd_queue #(.DATA_WIDTH(QDW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_op, push_dz, push_dy, push_dx}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // squares, sum and root
   mipd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_data[QDW-1]),
      .pop_dx     (pop_data[0 +: DW]),
      .pop_dy     (pop_data[DW +: DW]),
      .pop_dz     (pop_data[2*DW +: DW]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_dx     (rsp_dx),
      .rsp_dy     (rsp_dy),
      .rsp_dz     (rsp_dz),
      .rsp_length (rsp_length)
   );

   // result packing
   assign rsp_tdata = ODW'({rsp_length, rsp_dz, rsp_dy, rsp_dx});

endmodule
